>>> design/cpps_pkg.sv
package cpps_pkg;

    localparam int FLAG_COUNT     = 6;
    localparam int PLANES_DEF     = 6;
    localparam int COORD_BITS_DEF = 16;

    localparam int PLANE_W   = 64;
    localparam int COEF_W    = 16;
    localparam int MODES_W   = 33;
    localparam int BAND_W    = 20;
    localparam int CNT_LSB   = 30;
    localparam int CNT_W     = 3;
    localparam int SIDE_W    = 3;
    localparam int CROSS_W   = 2;
    localparam int MODE_STEP = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [BAND_W-1:0]     BAND_RESET = BAND_W'(16);
    localparam logic [FLAG_COUNT-1:0] ALL_FLAGS  = {FLAG_COUNT{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_MODES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_BAND   = 3'd7;

    localparam logic [SIDE_W-1:0] SIDE_A_POS    = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_A_NEG    = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_B_POS    = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_B_NEG    = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_C_POS    = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_C_NEG    = 3'd5;
    localparam logic [SIDE_W-1:0] SIDE_ON_PLANE = 3'd6;

    localparam logic [CROSS_W-1:0] CROSS_OFF   = 2'd0;
    localparam logic [CROSS_W-1:0] CROSS_ON    = 2'd1;
    localparam logic [CROSS_W-1:0] CROSS_CROSS = 2'd2;

    typedef struct packed {
        logic set;
        logic clr;
    } t_plane_act;

endpackage

>>> design/cpps_plane_test.sv
module cpps_plane_test
    import cpps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    input  logic [PLANE_W-1:0]           i_plane,
    input  logic [SIDE_W-1:0]            i_side,
    input  logic [CROSS_W-1:0]           i_cross,
    input  logic [BAND_W-1:0]            i_band,
    output t_plane_act                   o_act
);

    localparam int PROD_W = COORD_BITS + COEF_W;
    localparam int DIST_W = PROD_W + 2;
    localparam int CMP_W  = DIST_W + 1;

    logic signed [COEF_W-1:0] a, b, c, d;
    logic signed [PROD_W-1:0] px, py, pz;
    logic signed [DIST_W-1:0] distance;
    logic signed [CMP_W-1:0]  dist_w, band_w;
    logic on_band, neg, pos, cond, kept;

    assign a = i_plane[COEF_W-1:0];
    assign b = i_plane[2*COEF_W-1:COEF_W];
    assign c = i_plane[3*COEF_W-1:2*COEF_W];
    assign d = i_plane[4*COEF_W-1:3*COEF_W];

    assign px = i_x * a;
    assign py = i_y * b;
    assign pz = i_z * c;

    assign distance = DIST_W'(px) + DIST_W'(py) + DIST_W'(pz) - DIST_W'(d);
    assign dist_w   = CMP_W'(distance);
    assign band_w   = $signed(CMP_W'(i_band));

    // an exact zero is on the plane even with a zero band
    assign on_band = ((dist_w < band_w) && (dist_w > -band_w)) || (distance == '0);
    assign neg     = !on_band && distance[DIST_W-1];
    assign pos     = !on_band && !distance[DIST_W-1];

    always_comb begin
        case (i_side)
            SIDE_A_POS: cond = (a > 0);
            SIDE_A_NEG: cond = (a < 0);
            SIDE_B_POS: cond = (b > 0);
            SIDE_B_NEG: cond = (b < 0);
            SIDE_C_POS: cond = (c > 0);
            SIDE_C_NEG: cond = (c < 0);
            default:    cond = 1'b0;
        endcase
    end

    // kept side is negative distance when the side condition holds
    assign kept = cond ? neg : pos;

    always_comb begin
        o_act = '0;
        if (i_side == SIDE_ON_PLANE) begin
            if (on_band) begin
                o_act.set = (i_cross == CROSS_CROSS);
            end else begin
                o_act.clr = (i_cross == CROSS_OFF) || (i_cross == CROSS_ON);
            end
        end else if (on_band) begin
            o_act.clr = (i_cross == CROSS_OFF);
            o_act.set = (i_cross == CROSS_CROSS);
        end else if (kept) begin
            o_act.set = (i_cross == CROSS_CROSS);
        end else begin
            o_act.clr = (i_cross == CROSS_OFF) || (i_cross == CROSS_ON);
        end
    end

endmodule

>>> design/clip_plane_point_selector_unit.sv
// Tests each point word against up to PLANES configured planes and keeps a
// sticky found flag per plane for the current object. One word is accepted
// every cycle while o_stall is low. An accepted word goes to the input
// register, then to the result register that also holds the flags; a single
// pass of parallel dot products and the flag update lies between the two.
// A stalled result holds; the input stalls only while both registers are full.
// Config writes (planes, modes, near-zero band) must only happen while the
// block is idle.
module clip_plane_point_selector_unit
    import cpps_pkg::*;
#(
    parameter int PLANES     = PLANES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic                         i_object_start,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [FLAG_COUNT-1:0]        o_found_mask,
    output logic                         o_all_found
);

    logic [PLANE_W-1:0] r_plane [PLANES];
    logic [MODES_W-1:0] r_modes;
    logic [BAND_W-1:0]  r_band;

    logic                         r_in_valid;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic                         r_start;
    logic                         r_out_valid;
    logic [FLAG_COUNT-1:0]        r_flags;
    logic [FLAG_COUNT-1:0]        n_flags;

    logic accept_in, advance;
    logic [CNT_W-1:0]      cnt, active_n;
    logic [FLAG_COUNT-1:0] active, cross_mask, set_mask, clr_mask, base;
    t_plane_act            act [PLANES];

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= '0;
            r_band  <= BAND_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_PLANE_MODES) begin
                r_modes <= i_cfg_data[MODES_W-1:0];
            end
            if (i_cfg_index == REG_NEAR_BAND) begin
                r_band <= i_cfg_data[BAND_W-1:0];
            end
        end
    end

    for (genvar g = 0; g < PLANES; g++) begin : g_plane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_plane[g] <= '0;
            end else if (i_cfg_we && i_cfg_index == CFG_IDX_W'(g)) begin
                r_plane[g] <= i_cfg_data[PLANE_W-1:0];
            end
        end

        cpps_plane_test #(
            .COORD_BITS(COORD_BITS)
        ) u_test (
            .i_x    (r_x),
            .i_y    (r_y),
            .i_z    (r_z),
            .i_plane(r_plane[g]),
            .i_side (r_modes[MODE_STEP*g +: SIDE_W]),
            .i_cross(r_modes[MODE_STEP*g + SIDE_W +: CROSS_W]),
            .i_band (r_band),
            .o_act  (act[g])
        );
    end

    // active plane count, clamped
    assign cnt      = r_modes[CNT_LSB +: CNT_W];
    assign active_n = (cnt > CNT_W'(PLANES)) ? CNT_W'(PLANES) : cnt;

    always_comb begin
        active     = '0;
        cross_mask = '0;
        set_mask   = '0;
        clr_mask   = '0;
        for (int i = 0; i < PLANES; i++) begin
            active[i]     = (CNT_W'(i) < active_n);
            cross_mask[i] = active[i] &&
                (r_modes[MODE_STEP*i + SIDE_W +: CROSS_W] == CROSS_CROSS);
            set_mask[i]   = active[i] && act[i].set;
            clr_mask[i]   = active[i] && act[i].clr;
        end
        base    = r_start ? (ALL_FLAGS & ~cross_mask) : r_flags;
        n_flags = (base & ~clr_mask) | set_mask;
    end

    // handshake: input register, result register
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign accept_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept_in || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_x     <= i_point_x;
            r_y     <= i_point_y;
            r_z     <= i_point_z;
            r_start <= i_object_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= ALL_FLAGS;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_flags     <= n_flags;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found_mask = r_flags;
    assign o_all_found  = (r_flags == ALL_FLAGS);

endmodule

>>> design/cpps_checker.sv
module cpps_checker
    import cpps_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [FLAG_COUNT-1:0] o_found_mask,
    input logic                  o_all_found
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    a_all_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_all_found == (o_found_mask == ALL_FLAGS)))
        else $error("all_found disagrees with found_mask");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found_mask)))
        else $error("stalled result word changed");

endmodule

bind clip_plane_point_selector_unit cpps_checker u_cpps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_found_mask(o_found_mask),
    .o_all_found (o_all_found)
);

>>> test/tb_clip_plane_point_selector_unit.sv
`timescale 1ns / 1ps

module tb_clip_plane_point_selector_unit;
    import cpps_pkg::*;

    localparam int STUCK_LIMIT      = 4000;
    localparam int IDLE_PCT         = 24;
    localparam int RANDOM_PHASES    = 10;
    localparam int POINTS_PER_PHASE = 115;
    localparam int CALM_PHASE       = 5;
    localparam int PAUSE_PHASE      = 3;
    localparam int MAX_PRINTS       = 100;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_ZERO = 3'd0;
    localparam logic [SIDE_W-1:0]    SIDE_UNUSED    = 3'd7;
    localparam logic [CROSS_W-1:0]   CROSS_UNUSED   = 2'd3;
    localparam logic [BAND_W-1:0]    BAND_MAX       = {BAND_W{1'b1}};

    typedef enum logic [1:0] {KEEP_BEHIND, KEEP_FRONT, KEEP_ON_PLANE} t_keep_side;

    typedef struct {
        logic signed [COORD_BITS_DEF-1:0] x;
        logic signed [COORD_BITS_DEF-1:0] y;
        logic signed [COORD_BITS_DEF-1:0] z;
        logic                             start;
    } t_point_word;

    typedef struct {
        logic [FLAG_COUNT-1:0] mask;
        logic                  all;
    } t_flag_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [COORD_BITS_DEF-1:0] i_point_x = '0;
    logic [COORD_BITS_DEF-1:0] i_point_y = '0;
    logic [COORD_BITS_DEF-1:0] i_point_z = '0;
    logic                      i_object_start = 1'b0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [FLAG_COUNT-1:0]     o_found_mask;
    logic                      o_all_found;

    clip_plane_point_selector_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_object_start (i_object_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found_mask   (o_found_mask),
        .o_all_found    (o_all_found)
    );

    // shadow of the block's registers and flags
    logic [PLANE_W-1:0]    plane_reg [FLAG_COUNT];
    logic [MODES_W-1:0]    mode_reg = '0;
    logic [BAND_W-1:0]     band_reg = BAND_RESET;
    logic [FLAG_COUNT-1:0] flag_state = ALL_FLAGS;

    t_point_word point_queue[$];
    t_flag_word  flag_queue[$];
    int          points_issued = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          stuck_cycles = 0;
    int          idle_pct = IDLE_PCT;
    logic        in_accepted = 1'b0;

    initial begin
        for (int i = 0; i < FLAG_COUNT; i++) plane_reg[i] = '0;
    end

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] %s: got %0h expected %0h", $time, what, got, want);
    endtask

    function automatic t_flag_word predict_flags(input t_point_word w);
        int         n;
        longint     x, y, z, a, b, c, d, distance, mag;
        logic [SIDE_W-1:0]  s;
        logic [CROSS_W-1:0] cr;
        t_keep_side keep;
        logic       set_f, clr_f;
        t_flag_word r;
        n = int'(mode_reg[CNT_LSB +: CNT_W]);
        if (n > PLANES_DEF) n = PLANES_DEF;
        x = w.x;
        y = w.y;
        z = w.z;
        if (w.start) begin
            flag_state = ALL_FLAGS;
            for (int i = 0; i < n; i++)
                if (mode_reg[MODE_STEP*i+SIDE_W +: CROSS_W] == CROSS_CROSS)
                    flag_state[i] = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            a = $signed(plane_reg[i][0 +: COEF_W]);
            b = $signed(plane_reg[i][COEF_W +: COEF_W]);
            c = $signed(plane_reg[i][2*COEF_W +: COEF_W]);
            d = $signed(plane_reg[i][3*COEF_W +: COEF_W]);
            s = mode_reg[MODE_STEP*i +: SIDE_W];
            cr = mode_reg[MODE_STEP*i+SIDE_W +: CROSS_W];
            if ((s == SIDE_A_POS && a > 0) || (s == SIDE_A_NEG && a < 0) ||
                (s == SIDE_B_POS && b > 0) || (s == SIDE_B_NEG && b < 0) ||
                (s == SIDE_C_POS && c > 0) || (s == SIDE_C_NEG && c < 0))
                keep = KEEP_BEHIND;
            else if (s == SIDE_ON_PLANE)
                keep = KEEP_ON_PLANE;
            else
                keep = KEEP_FRONT;
            distance = x * a + y * b + z * c - d;
            mag = (distance < 0) ? -distance : distance;
            if (mag < longint'(band_reg)) distance = 0;
            set_f = 1'b0;
            clr_f = 1'b0;
            if (keep == KEEP_ON_PLANE) begin
                if (distance == 0) set_f = (cr == CROSS_CROSS);
                else clr_f = (cr == CROSS_OFF || cr == CROSS_ON);
            end else if (distance == 0) begin
                clr_f = (cr == CROSS_OFF);
                set_f = (cr == CROSS_CROSS);
            end else if ((keep == KEEP_BEHIND && distance < 0) ||
                         (keep == KEEP_FRONT && distance > 0)) begin
                set_f = (cr == CROSS_CROSS);
            end else begin
                clr_f = (cr == CROSS_OFF || cr == CROSS_ON);
            end
            if (clr_f) flag_state[i] = 1'b0;
            if (set_f) flag_state[i] = 1'b1;
        end
        r.mask = flag_state;
        r.all = (flag_state == ALL_FLAGS);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == REG_PLANE_MODES) mode_reg = data[MODES_W-1:0];
        else if (idx == REG_NEAR_BAND) band_reg = data[BAND_W-1:0];
        else plane_reg[idx] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_point(input logic [COORD_BITS_DEF-1:0] x, input logic [COORD_BITS_DEF-1:0] y,
                             input logic [COORD_BITS_DEF-1:0] z, input logic start);
        t_point_word w;
        w.x = x;
        w.y = y;
        w.z = z;
        w.start = start;
        point_queue.push_back(w);
        points_issued++;
    endtask

    task automatic drain();
        while (results_seen != points_issued) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic logic [PLANE_W-1:0] plane_word(input logic [COEF_W-1:0] a,
                                                       input logic [COEF_W-1:0] b,
                                                       input logic [COEF_W-1:0] c,
                                                       input logic [COEF_W-1:0] d);
        return {d, c, b, a};
    endfunction

    function automatic logic [MODES_W-1:0] mode_field(input int i, input logic [SIDE_W-1:0] s,
                                                      input logic [CROSS_W-1:0] cr);
        logic [MODES_W-1:0] m;
        m = '0;
        m[MODE_STEP*i +: SIDE_W] = s;
        m[MODE_STEP*i+SIDE_W +: CROSS_W] = cr;
        return m;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(7))
            0: return '0;
            1: return 16'(16384);
            2: return 16'(-16384);
            3: return 16'h7FFF;
            4: return 16'h8000;
            5: return 16'(int'($urandom_range(128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_BITS_DEF-1:0] rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'(int'($urandom_range(16)) - 8);
            4, 5: return 16'(int'($urandom_range(1024)) - 512);
            6: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            7: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_setup(input int ph);
        logic [MODES_W-1:0]  m;
        logic [BAND_W-1:0]   band;
        logic [PLANE_W-1:0]  p;
        for (int i = 0; i < FLAG_COUNT; i++) begin
            if ($urandom_range(5) == 0) p = {$urandom, $urandom};
            else p = plane_word(rand_coef(), rand_coef(), rand_coef(), rand_coef());
            write_reg(REG_PLANE_ZERO + CFG_IDX_W'(i), p);
        end
        m = '0;
        for (int i = 0; i < FLAG_COUNT; i++)
            m |= mode_field(i, SIDE_W'($urandom_range(7)),
                            ($urandom_range(9) == 0) ? CROSS_UNUSED : CROSS_W'($urandom_range(2)));
        m[CNT_LSB +: CNT_W] = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(7)) : CNT_W'(PLANES_DEF);
        write_reg(REG_PLANE_MODES, {31'($urandom), m});
        case (ph == 0 ? 5 : ph == 1 ? 6 : $urandom_range(4))
            0: band = BAND_RESET;
            1: band = BAND_W'($urandom);
            2: band = BAND_W'($urandom_range(70000));
            3: band = BAND_W'($urandom_range(300));
            5: band = BAND_MAX;
            6: band = '0;
            default: band = BAND_W'($urandom_range(20000));
        endcase
        write_reg(REG_NEAR_BAND, {$urandom, 12'($urandom), band});
    endtask

    // driver: sender and receiver side
    always @(negedge i_clk) begin
        t_point_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || in_accepted) begin
                if (point_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    w = point_queue.pop_front();
                    i_valid <= 1'b1;
                    i_point_x <= w.x;
                    i_point_y <= w.y;
                    i_point_z <= w.z;
                    i_object_start <= w.start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_point_word w;
        t_flag_word  want;
        logic        out_accepted;
        in_accepted = i_rst_n && i_valid && !o_stall;
        out_accepted = i_rst_n && o_valid && !i_stall;
        if (in_accepted) begin
            w.x = i_point_x;
            w.y = i_point_y;
            w.z = i_point_z;
            w.start = i_object_start;
            flag_queue.push_back(predict_flags(w));
        end
        if (out_accepted) begin
            results_seen++;
            if (flag_queue.size() == 0) begin
                report_mismatch("word with no expectation", o_found_mask, 0);
            end else begin
                want = flag_queue.pop_front();
                if (o_found_mask !== want.mask)
                    report_mismatch("found_mask", o_found_mask, want.mask);
                if (o_all_found !== want.all)
                    report_mismatch("all_found", o_all_found, want.all);
            end
        end
        if (in_accepted || out_accepted) stuck_cycles = 0;
        else stuck_cycles++;
    end

    always @(negedge i_clk) begin
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [MODES_W-1:0] m;
        int pushed, len;
        logic broken, paused, start;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: no active planes, flags stay set
        add_point(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        add_point(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
        add_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
        drain();

        // one plane per side code, mixed cross modes
        write_reg(REG_PLANE_ZERO + 3'd0, plane_word(16'(16384), 16'd0, 16'd0, 16'd0));
        write_reg(REG_PLANE_ZERO + 3'd1, plane_word(16'(-16384), 16'd0, 16'd0, 16'(16384 * 3)));
        write_reg(REG_PLANE_ZERO + 3'd2, plane_word(16'd0, 16'(16384), 16'(8192), 16'(-16384)));
        write_reg(REG_PLANE_ZERO + 3'd3, plane_word(16'd5, 16'(-16384), 16'd0, 16'd0));
        write_reg(REG_PLANE_ZERO + 3'd4, plane_word(16'd0, 16'd0, 16'(16384), 16'd8));
        write_reg(REG_PLANE_ZERO + 3'd5, plane_word(16'd0, 16'd0, 16'(-16384), 16'h8000));
        m = mode_field(0, SIDE_A_POS, CROSS_OFF) | mode_field(1, SIDE_A_NEG, CROSS_ON) |
            mode_field(2, SIDE_B_POS, CROSS_CROSS) | mode_field(3, SIDE_B_NEG, CROSS_CROSS) |
            mode_field(4, SIDE_C_POS, CROSS_OFF) | mode_field(5, SIDE_C_NEG, CROSS_ON);
        m[CNT_LSB +: CNT_W] = CNT_W'(PLANES_DEF);
        write_reg(REG_PLANE_MODES, CFG_DATA_W'(m));
        add_point(16'd0, 16'd0, 16'd0, 1'b1);
        add_point(16'd1, 16'd1, 16'd1, 1'b0);
        add_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_point(16'd3, 16'd0, 16'd0, 1'b0);
        add_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        add_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
        add_point(16'd0, 16'd0, 16'd0, 1'b0);
        add_point(16'd2, 16'hFFFF, 16'hFFFE, 1'b0);
        add_point(16'd5, 16'd5, 16'd5, 1'b1);
        drain();

        // on-plane and meaningless codes, count above the plane total, zero band
        m = mode_field(0, SIDE_ON_PLANE, CROSS_CROSS) | mode_field(1, SIDE_UNUSED, CROSS_UNUSED) |
            mode_field(2, SIDE_ON_PLANE, CROSS_OFF) | mode_field(3, SIDE_A_POS, CROSS_CROSS) |
            mode_field(4, SIDE_A_NEG, CROSS_CROSS) | mode_field(5, SIDE_B_POS, CROSS_ON);
        m[CNT_LSB +: CNT_W] = 3'd7;
        write_reg(REG_PLANE_MODES, CFG_DATA_W'(m));
        write_reg(REG_NEAR_BAND, '0);
        add_point(16'd0, 16'd0, 16'd0, 1'b1);
        add_point(16'd0, 16'd0, 16'd0, 1'b0);
        add_point(16'd1, 16'd0, 16'd0, 1'b0);
        add_point(16'd0, 16'd2, 16'd0, 1'b0);
        add_point(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        drain();

        // plane zero, modes and band at their top values, plane one at its extremes
        write_reg(REG_PLANE_ZERO + 3'd0, {CFG_DATA_W{1'b1}});
        write_reg(REG_PLANE_ZERO + 3'd1, plane_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        write_reg(REG_PLANE_MODES, {CFG_DATA_W{1'b1}});
        write_reg(REG_NEAR_BAND, CFG_DATA_W'(BAND_MAX));
        add_point(16'd0, 16'd0, 16'd0, 1'b1);
        add_point(16'd40, 16'hFFD8, 16'd3, 1'b0);
        add_point(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        add_point(16'h8000, 16'h8000, 16'h8000, 1'b1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_pct = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
            random_setup(ph);
            pushed = 0;
            paused = 1'b0;
            while (pushed < POINTS_PER_PHASE) begin
                len = $urandom_range(12, 1);
                broken = ($urandom_range(9) == 0);
                for (int j = 0; j < len; j++) begin
                    start = broken ? 1'($urandom_range(1)) : (j == 0);
                    add_point(rand_coord(), rand_coord(), rand_coord(), start);
                end
                pushed += len;
                if (ph == PAUSE_PHASE && !paused && pushed >= POINTS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (flag_queue.size() != 0)
            report_mismatch("expectations left over", flag_queue.size(), 0);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
